// ===== design/lzwc_pkg.sv =====
// Shared types and constants for the LZW byte compressor.
`default_nettype none
package lzwc_pkg;

  localparam int DICT_SIZE    = 4096;
  localparam int STORE_DEPTH  = 4096;
  localparam int CODE_W       = 12;
  localparam int BYTE_W       = 8;
  localparam int FREE_W       = 13;
  localparam int DICT_LIMIT_I = (DICT_SIZE < STORE_DEPTH) ? DICT_SIZE : STORE_DEPTH;
  localparam int FIRST_FREE_I = 256;

  localparam logic [FREE_W-1:0] DICT_LIMIT   = FREE_W'(DICT_LIMIT_I);
  localparam logic [FREE_W-1:0] FIRST_FREE   = FREE_W'(FIRST_FREE_I);
  localparam logic [CODE_W-1:0] FIRST_CHILD  = CODE_W'(FIRST_FREE_I);
  localparam logic [CODE_W-1:0] NO_CODE      = '0;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_CMP
  } state_t;

  // Entry per code: next sibling under the same prefix, prefix code, byte
  typedef struct packed {
    code_t             sib;
    code_t             prefix;
    logic [BYTE_W-1:0] data_b;
  } dict_ent_t;

  typedef struct packed {
    logic      fc_we;
    code_t     fc_waddr;
    code_t     fc_wdata;
    code_t     fc_raddr;
    logic      ent_we;
    code_t     ent_waddr;
    dict_ent_t ent_wdata;
    code_t     ent_raddr;
  } dict_req_t;

  typedef struct packed {
    code_t     fc_rdata;
    dict_ent_t ent_rdata;
  } dict_rsp_t;

  typedef struct packed {
    logic  last;
    code_t code;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/lzwc_dict.sv =====
// Dictionary storage: first-child table per prefix and entry table per code.
`default_nettype none
module lzwc_dict (
  input  wire                  clk,
  input  wire lzwc_pkg::dict_req_t req,
  output lzwc_pkg::dict_rsp_t  rsp
);
  import lzwc_pkg::*;

  code_t     fc_mem  [STORE_DEPTH];
  dict_ent_t ent_mem [STORE_DEPTH];
  code_t     fc_rdata_r;
  dict_ent_t ent_rdata_r;

  always_ff @(posedge clk) begin
    if (req.fc_we) begin
      fc_mem[req.fc_waddr] <= req.fc_wdata;
    end
    fc_rdata_r <= fc_mem[req.fc_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      ent_mem[req.ent_waddr] <= req.ent_wdata;
    end
    ent_rdata_r <= ent_mem[req.ent_raddr];
  end

  assign rsp.fc_rdata  = fc_rdata_r;
  assign rsp.ent_rdata = ent_rdata_r;

endmodule
`default_nettype wire

// ===== design/lzw_byte_compressor.sv =====
// LZW byte compressor top level: trie walk controller and result queue.
// Flow: a byte with no prefix held is taken in the idle state; otherwise the first-child
// pointer of the prefix is read, and the item ends there when it is empty or beyond this
// stream's codes, else entries are read one sibling at a time until a match or list end.
// Results enter a 4-deep queue the cycle after the item finishes; a beat is taken
// while up to two results wait. Reset starts a clearing pass over all 4096 first-child entries.
`default_nettype none
module lzw_byte_compressor (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [11:0] code, [15:12] zero
  output logic        out_tlast   // last_code
);
  import lzwc_pkg::*;

  state_t              state_r, state_nxt;
  code_t               clr_cnt_r, clr_cnt_nxt;
  logic                prefix_valid_r, prefix_valid_nxt;
  code_t               prefix_code_r, prefix_code_nxt;
  logic [FREE_W-1:0]   next_free_r, next_free_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                eos_r, eos_nxt;
  code_t               cand_r, cand_nxt;
  code_t               head_r, head_nxt;
  logic                first_r, first_nxt;

  out_item_t           fifo_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;

  dict_req_t           req;
  dict_rsp_t           rsp;

  logic                in_fire, pop;
  logic [1:0]          push_n;
  out_item_t           push_a, push_b;
  logic                hit, miss;
  code_t               new_sib, new_prefix;
  code_t               byte_code;
  dict_ent_t           ent;

  lzwc_dict u_dict (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign in_tready  = (state_r == S_IDLE) && (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {4'b0, fifo_mem_r[rd_ptr_r].code};
  assign out_tlast  = fifo_mem_r[rd_ptr_r].last;
  assign byte_code  = CODE_W'(byte_r);
  assign ent        = rsp.ent_rdata;

  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    prefix_valid_nxt = prefix_valid_r;
    prefix_code_nxt  = prefix_code_r;
    next_free_nxt    = next_free_r;
    byte_nxt         = byte_r;
    eos_nxt          = eos_r;
    cand_nxt         = cand_r;
    head_nxt         = head_r;
    first_nxt        = first_r;
    req              = '0;
    push_n           = 2'd0;
    push_a           = '0;
    push_b           = '0;
    hit              = 1'b0;
    miss             = 1'b0;
    new_sib          = NO_CODE;
    new_prefix       = prefix_code_r;

    case (state_r)
      S_CLEAR: begin
        req.fc_we    = 1'b1;
        req.fc_waddr = clr_cnt_r;
        req.fc_wdata = NO_CODE;
        clr_cnt_nxt  = clr_cnt_r + CODE_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_tdata;
          eos_nxt  = in_tlast;
          if (!prefix_valid_r) begin
            if (in_tlast) begin
              push_n      = 2'd1;
              push_a.last = 1'b1;
              push_a.code = CODE_W'(in_tdata);
            end else begin
              prefix_code_nxt  = CODE_W'(in_tdata);
              prefix_valid_nxt = 1'b1;
            end
          end else begin
            req.fc_raddr = prefix_code_r;
            state_nxt    = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cand_nxt      = rsp.fc_rdata;
        head_nxt      = rsp.fc_rdata;
        first_nxt     = 1'b1;
        req.ent_raddr = rsp.fc_rdata;
        if ((rsp.fc_rdata >= FIRST_CHILD) &&
            ({1'b0, rsp.fc_rdata} < next_free_r)) begin
          state_nxt = S_CMP;
        end else begin
          miss    = 1'b1;
          new_sib = NO_CODE;
        end
      end
      S_CMP: begin
        if (first_r && (ent.prefix != prefix_code_r)) begin
          miss    = 1'b1;
          new_sib = NO_CODE;
        end else if (ent.data_b == byte_r) begin
          hit = 1'b1;
        end else if (ent.sib != NO_CODE) begin
          cand_nxt      = ent.sib;
          req.ent_raddr = ent.sib;
          first_nxt     = 1'b0;
        end else begin
          miss    = 1'b1;
          new_sib = head_r;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (miss) begin
      push_n      = 2'd1;
      push_a.last = 1'b0;
      push_a.code = prefix_code_r;
      new_prefix  = byte_code;
      if (next_free_r < DICT_LIMIT) begin
        req.ent_we           = 1'b1;
        req.ent_waddr        = next_free_r[CODE_W-1:0];
        req.ent_wdata.sib    = new_sib;
        req.ent_wdata.prefix = prefix_code_r;
        req.ent_wdata.data_b = byte_r;
        req.fc_we            = 1'b1;
        req.fc_waddr         = prefix_code_r;
        req.fc_wdata         = next_free_r[CODE_W-1:0];
        next_free_nxt        = next_free_r + FREE_W'(1);
      end
    end
    if (hit) begin
      new_prefix = cand_r;
    end

    if (hit || miss) begin
      state_nxt = S_IDLE;
      if (eos_r) begin
        if (miss) begin
          push_n      = 2'd2;
          push_b.last = 1'b1;
          push_b.code = new_prefix;
        end else begin
          push_n      = 2'd1;
          push_a.last = 1'b1;
          push_a.code = new_prefix;
        end
        prefix_valid_nxt = 1'b0;
        prefix_code_nxt  = '0;
        next_free_nxt    = FIRST_FREE;
      end else begin
        prefix_code_nxt = new_prefix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      prefix_valid_r <= 1'b0;
      prefix_code_r  <= '0;
      next_free_r    <= FIRST_FREE;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      cnt_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      prefix_valid_r <= prefix_valid_nxt;
      prefix_code_r  <= prefix_code_nxt;
      next_free_r    <= next_free_nxt;
      wr_ptr_r       <= wr_ptr_r + OUT_PTR_W'(push_n);
      rd_ptr_r       <= rd_ptr_r + OUT_PTR_W'(pop);
      cnt_r          <= cnt_r + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    eos_r   <= eos_nxt;
    cand_r  <= cand_nxt;
    head_r  <= head_nxt;
    first_r <= first_nxt;
    if (push_n != 2'd0) begin
      fifo_mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo_mem_r[wr_ptr_r + OUT_PTR_W'(1)] <= push_b;
    end
  end

endmodule
`default_nettype wire

// ===== design/lzwc_check.sv =====
// Port-level checker for the LZW byte compressor, bound to the top level.
`default_nettype none
module lzwc_check (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire        out_tlast
);

  // Codes are 12 bits wide; pad bits stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'b0))
    else $error("out_tdata pad bits set");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result beat changed");

  // Reset starts the table clearing pass: no input beat taken right after.
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // Reset empties the result queue.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind lzw_byte_compressor lzwc_check u_lzwc_check (.*);
`default_nettype wire

// ===== tb/sv/lzw_byte_compressor_chk.sv =====
// Checker for lzw_byte_compressor: predicts codes from accepted bytes and checks out beats.
module lzw_byte_compressor_chk (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [7:0]  in_tdata,
  input  wire        in_tlast,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [15:0] out_tdata,
  input  wire        out_tlast,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lzwc_pkg::*;

  localparam int PAIR_W = CODE_W + BYTE_W;

  code_t             prefix_code;
  logic              prefix_held;
  logic [FREE_W-1:0] next_code;
  code_t             code_of_pair [logic [PAIR_W-1:0]];
  out_item_t         codes_due [$];

  task automatic compress_byte(input logic [BYTE_W-1:0] data_b, input logic eos);
    logic [PAIR_W-1:0] pair;
    out_item_t         item;
    if (!prefix_held) begin
      prefix_code = code_t'(data_b);
      prefix_held = 1'b1;
    end else begin
      pair = {prefix_code, data_b};
      if (code_of_pair.exists(pair)) begin
        prefix_code = code_of_pair[pair];
      end else begin
        item.code = prefix_code;
        item.last = 1'b0;
        codes_due = {codes_due, item};
        if (next_code < DICT_LIMIT) begin
          code_of_pair[pair] = next_code[CODE_W-1:0];
          next_code = next_code + 1'b1;
        end
        prefix_code = code_t'(data_b);
      end
    end
    if (eos) begin
      item.code = prefix_code;
      item.last = 1'b1;
      codes_due = {codes_due, item};
      prefix_held = 1'b0;
      prefix_code = '0;
      next_code   = FIRST_FREE;
      code_of_pair.delete();
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      prefix_code = '0;
      prefix_held = 1'b0;
      next_code   = FIRST_FREE;
      code_of_pair.delete();
      codes_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (codes_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected beat: code %0d last %0d", out_tdata, out_tlast);
          fail_count++;
        end else begin
          exp_item = codes_due.pop_front();
          if (out_tdata !== {{(16-CODE_W){1'b0}}, exp_item.code} ||
              out_tlast !== exp_item.last) begin
            if (fail_count < 10)
              $display("mismatch: code exp %0d got %0d, last exp %0d got %0d",
                       exp_item.code, out_tdata, exp_item.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        compress_byte(in_tdata, in_tlast);
    end
    pending = codes_due.size();
  end

endmodule

// ===== tb/sv/lzw_byte_compressor_tb.sv =====
// Testbench top for lzw_byte_compressor: byte streams, idling phases, watchdog and verdict.
module lzw_byte_compressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  lzw_byte_compressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lzw_byte_compressor_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lzw_byte_compressor regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic [7:0] data_b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data_b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // small alphabets give long matches, full range gives mostly misses
  task automatic send_stream(input int len);
    int         alpha;
    logic [7:0] sym [16];
    logic [7:0] data_b;
    case ($urandom_range(3))
      0: alpha = 2;
      1: alpha = 4;
      2: alpha = 16;
      default: alpha = 256;
    endcase
    foreach (sym[k]) sym[k] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      data_b = (alpha == 256) ? 8'($urandom) : sym[$urandom_range(alpha-1)];
      send_beat(data_b, i == len - 1);
    end
  endtask

  task automatic send_random(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 60);
      send_stream(len);
      sent += len;
    end
  endtask

  initial begin
    logic [7:0] sym [4];
    logic [7:0] data_b;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // one-byte streams at both extremes
    send_beat(8'h00, 1'b1);
    send_beat(8'hff, 1'b1);
    for (int i = 0; i < 8; i++) send_beat((i % 2) ? 8'h62 : 8'h61, i == 7);
    for (int i = 0; i < 5; i++) send_beat((i % 2) ? 8'hff : 8'h00, i == 4);
    // repeated byte: code used right after it is added
    for (int i = 0; i < 6; i++) send_beat(8'h55, i == 5);

    send_random(260);

    // one long stream: wide bytes first, then a narrow alphabet
    foreach (sym[k]) sym[k] = 8'($urandom);
    for (int i = 0; i < 300; i++) begin
      data_b = (i < 200) ? 8'($urandom) : sym[$urandom_range(3)];
      send_beat(data_b, i == 299);
    end

    idle_pct = 66;
    send_random(260);
    idle_pct  = 0;
    stall_pct = 66;
    send_random(260);
    idle_pct  = 6;
    stall_pct = 6;
    send_random(260);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("lzw_byte_compressor regression: pass");
    else
      $display("lzw_byte_compressor regression: fail");
    $finish;
  end

endmodule
